>>> design/garp_pkg.sv
// ----------------------------------------------------------------------------
// garp_pkg: shared types and constants of the atlas rectangle packer
// ----------------------------------------------------------------------------
`default_nettype none
package garp_pkg;
  localparam int unsigned MaxFree   = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned SlotBits  = $clog2(MaxFree);
  localparam int unsigned CntBits   = $clog2(MaxFree + 1);
  localparam int unsigned DimBits   = 11;
  localparam int unsigned RectBits  = 4 * CoordBits;
  localparam logic [CoordBits-1:0] CMax = {CoordBits{1'b1}};
  localparam logic [3:0] BorderReset = 4'd1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [SlotBits-1:0]  slot_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  // channel payloads
  typedef struct packed {
    logic [3:0] border_pixels;
  } cfg_t;

  typedef struct packed {
    logic [DimBits-1:0] image_width;
    logic [DimBits-1:0] image_height;
  } place_req_t;

  typedef struct packed {
    coord_t     place_x;
    coord_t     place_y;
    coord_t     atlas_width;
    coord_t     atlas_height;
    logic [1:0] status;
  } place_rsp_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WAIT, S_DECIDE, S_FREE1, S_PUT1, S_FREE2, S_PUT2, S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, clear scan
    logic scan_rd;   // issue read of scan slot
    logic scan_en;   // evaluate returned data
    logic decide;    // compute placement and leftovers
    logic find;      // start free slot search
    logic put_sel;   // 0 first leftover, 1 second
    logic put_wr;    // write leftover if found
    logic out_load;  // load result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic find_last;
  } dp_sts_t;
endpackage
`default_nettype wire

>>> design/garp_if.sv
// ----------------------------------------------------------------------------
// garp_if: valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
`default_nettype none
interface garp_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/guillotine_atlas_rect_packer_unit.sv
// ----------------------------------------------------------------------------
// guillotine_atlas_rect_packer_unit: best-area-fit guillotine atlas packer
// a request scans the free table through one ram read port, then each of the
// two leftovers searches the valid bits for a free slot before it is written;
// one request at a time, and a waiting result holds the last step; the result
// register lets the next request in
// reset: free table empty, atlas 0 x 0, border 1; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none
module guillotine_atlas_rect_packer_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  garp_if.sink      cfg,
  garp_if.sink      req,
  garp_if.source    rsp
);
  import garp_pkg::*;

  logic [3:0] border_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [15:0] px, py, aw, ah;
  logic [1:0] st;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q <= BorderReset;
    end else if (cfg.valid) begin
      border_q <= cfg.data.border_pixels;
    end
  end

  garp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .out_valid_o(rsp.valid),
    .out_ready_i(rsp.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  garp_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .border_i(border_q),
    .in_w_i  (req.data.image_width),
    .in_h_i  (req.data.image_height),
    .px_o    (px),
    .py_o    (py),
    .aw_o    (aw),
    .ah_o    (ah),
    .status_o(st)
  );

  assign rsp.data.place_x      = px;
  assign rsp.data.place_y      = py;
  assign rsp.data.atlas_width  = aw;
  assign rsp.data.atlas_height = ah;
  assign rsp.data.status       = st;

  // result never changes while it waits; place_y and status are checked
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> $stable(rsp.data.place_y) && $stable(rsp.data.status))
    else $error("result changed while stalled");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("second request taken while busy");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> rsp.data.status != 2'd3)
    else $error("bad status code");
endmodule
`default_nettype wire

>>> design/garp_ram.sv
// ----------------------------------------------------------------------------
// garp_ram: single-port RAM with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module garp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> design/garp_datapath.sv
// ----------------------------------------------------------------------------
// garp_datapath: free table, best-area scan, split and growth arithmetic
// ----------------------------------------------------------------------------
`default_nettype none
module garp_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire garp_pkg::dp_cmd_t   cmd_i,
  output garp_pkg::dp_sts_t        sts_o,
  input  wire logic [3:0]          border_i,
  input  wire logic [10:0]         in_w_i,
  input  wire logic [10:0]         in_h_i,
  output logic [15:0]              px_o,
  output logic [15:0]              py_o,
  output logic [15:0]              aw_o,
  output logic [15:0]              ah_o,
  output logic [1:0]               status_o
);
  import garp_pkg::*;

  logic [MaxFree-1:0] valid_q;
  coord_t aw_q, ah_q, pw_q, ph_q, px_q, py_q;
  logic [CntBits-1:0] scan_q, find_q;
  slot_t rd_slot_q;
  logic rd_ok_q;
  logic hit_q;
  slot_t best_q;
  logic [2*CoordBits-1:0] best_area_q;
  rect_t best_rect_q;
  rect_t lo_q [2];
  logic [1:0] lo_en_q;
  logic full_q, sat_q;
  logic found_q;
  slot_t free_slot_q;

  logic ram_we;
  slot_t ram_addr;
  rect_t ram_wdata, ram_rdata;

  garp_ram #(.Width(RectBits), .Depth(MaxFree)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic [CoordBits-1:0] pad;
  assign pad = CoordBits'({border_i, 1'b0});

  logic [2*CoordBits-1:0] area;
  logic fits;
  assign area = ram_rdata.w * ram_rdata.h;
  assign fits = rd_ok_q && valid_q[rd_slot_q] && ram_rdata.w >= pw_q && ram_rdata.h >= ph_q;

  // growth arithmetic
  logic [CoordBits:0] sum;
  coord_t new_ah, new_aw, new_h;
  always_comb begin
    sum    = {1'b0, ah_q} + {1'b0, ph_q};
    new_ah = sum[CoordBits] ? CMax : sum[CoordBits-1:0];
    new_aw = (aw_q < pw_q) ? pw_q : aw_q;
    new_h  = new_ah - ah_q;
  end

  assign sts_o.scan_last = (scan_q == CntBits'(MaxFree));
  assign sts_o.find_last = found_q || (find_q == CntBits'(MaxFree));

  logic cur_en;
  assign cur_en = lo_en_q[cmd_i.put_sel];
  assign ram_we   = cmd_i.put_wr && cur_en && found_q;
  assign ram_addr = cmd_i.put_wr ? free_slot_q : scan_q[SlotBits-1:0];
  assign ram_wdata = lo_q[cmd_i.put_sel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      aw_q    <= '0;
      ah_q    <= '0;
      scan_q  <= '0;
      find_q  <= '0;
      rd_ok_q <= 1'b0;
      hit_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        scan_q  <= '0;
        hit_q   <= 1'b0;
        full_q  <= 1'b0;
        sat_q   <= 1'b0;
        pw_q    <= CoordBits'(in_w_i) + pad;
        ph_q    <= CoordBits'(in_h_i) + pad;
      end
      rd_ok_q <= cmd_i.scan_rd;
      if (cmd_i.scan_rd) begin
        rd_slot_q <= scan_q[SlotBits-1:0];
        scan_q    <= scan_q + 1'b1;
      end
      if (cmd_i.scan_en && fits && (!hit_q || area < best_area_q)) begin
        hit_q       <= 1'b1;
        best_q      <= rd_slot_q;
        best_area_q <= area;
        best_rect_q <= ram_rdata;
      end
      if (cmd_i.decide) begin
        if (hit_q) begin
          valid_q[best_q] <= 1'b0;
          px_q <= best_rect_q.x;
          py_q <= best_rect_q.y;
          lo_q[0] <= '{x: best_rect_q.x + pw_q, y: best_rect_q.y,
                       w: best_rect_q.w - pw_q, h: ph_q};
          lo_en_q[0] <= best_rect_q.w > pw_q && ph_q != '0;
          lo_q[1] <= '{x: best_rect_q.x, y: best_rect_q.y + ph_q,
                       w: best_rect_q.w, h: best_rect_q.h - ph_q};
          lo_en_q[1] <= best_rect_q.h > ph_q && best_rect_q.w != '0;
        end else begin
          ah_q  <= new_ah;
          aw_q  <= new_aw;
          sat_q <= sum[CoordBits];
          px_q  <= '0;
          py_q  <= ah_q;
          lo_q[0] <= '{x: aw_q, y: '0, w: new_aw - aw_q, h: ah_q};
          lo_en_q[0] <= new_aw > aw_q && ah_q != '0;
          lo_q[1] <= '{x: pw_q, y: ah_q, w: new_aw - pw_q, h: new_h};
          lo_en_q[1] <= pw_q < new_aw && new_h != '0;
        end
      end
      if (cmd_i.find) begin
        find_q  <= '0;
        found_q <= 1'b0;
      end else if (!sts_o.find_last) begin
        // one slot per cycle, first invalid wins
        if (!valid_q[find_q[SlotBits-1:0]]) begin
          found_q     <= 1'b1;
          free_slot_q <= find_q[SlotBits-1:0];
        end else begin
          find_q <= find_q + 1'b1;
        end
      end
      if (cmd_i.put_wr && cur_en) begin
        if (found_q) begin
          valid_q[free_slot_q] <= 1'b1;
        end else begin
          full_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        px_o <= px_q;
        py_o <= py_q;
        aw_o <= aw_q;
        ah_o <= ah_q;
        status_o <= sat_q ? ST_SAT : (full_q ? ST_FULL : ST_OK);
      end
    end
  end
endmodule
`default_nettype wire

>>> design/garp_ctrl.sv
// ----------------------------------------------------------------------------
// garp_ctrl: sequencer for scan, decide and leftover writes
// ----------------------------------------------------------------------------
`default_nettype none
module garp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output garp_pkg::dp_cmd_t      cmd_o,
  input  wire garp_pkg::dp_sts_t sts_i
);
  import garp_pkg::*;

  state_e state_q, state_d;
  logic ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    ovalid_d   = ovalid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_WAIT;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      S_WAIT: begin
        cmd_o.scan_en = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = S_FREE1;
      end
      S_FREE1: begin
        cmd_o.find = 1'b1;
        state_d = S_PUT1;
      end
      S_PUT1: begin
        if (sts_i.find_last) begin
          cmd_o.put_wr = 1'b1;
          state_d = S_FREE2;
        end
      end
      S_FREE2: begin
        cmd_o.find = 1'b1;
        cmd_o.put_sel = 1'b1;
        state_d = S_PUT2;
      end
      S_PUT2: begin
        cmd_o.put_sel = 1'b1;
        if (sts_i.find_last) begin
          cmd_o.put_wr = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire
